// ===== rtl/core/vns_pkg.sv =====
`default_nettype none

package vns_pkg;

   // Default component width; the fixed-point scale does not change the datapath.
   localparam int COMPONENT_WIDTH_DEFAULT = 16;

endpackage

`default_nettype wire

// ===== rtl/core/vns_sqrt.sv =====
`default_nettype none

// Pipelined restoring square root, one result bit per stage, then a rounding stage.
module vns_sqrt #(
   parameter int COMPONENT_WIDTH = vns_pkg::COMPONENT_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [2*COMPONENT_WIDTH-1:0]   rad_in,
   output logic [COMPONENT_WIDTH-1:0]     len_out
);

   localparam int W = COMPONENT_WIDTH;

   logic [2*W-1:0] rad_ff  [1:W];
   logic [W+1:0]   rem_ff  [1:W];
   logic [W-1:0]   root_ff [1:W];
   logic [W-1:0]   len_ff;

   for (genvar i = 0; i < W; i++) begin : g_step
      logic [2*W-1:0] rad_prev;
      logic [W+1:0]   rem_prev;
      logic [W-1:0]   root_prev;
      logic [W+1:0]   acc;
      logic [W+1:0]   trial;
      logic           take;

      if (i == 0) begin : g_first
         assign rad_prev  = rad_in;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_rest
         assign rad_prev  = rad_ff[i];
         assign rem_prev  = rem_ff[i];
         assign root_prev = root_ff[i];
      end

      // remainder is at most 2*root, so the low W bits carry it
      assign acc   = {rem_prev[W-1:0], rad_prev[2*W-1 -: 2]};
      assign trial = {root_prev, 2'b01};
      assign take  = (acc >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[i+1]  <= rad_prev << 2;
            rem_ff[i+1]  <= take ? (acc - trial) : acc;
            root_ff[i+1] <= {root_prev[W-2:0], take};
         end
      end
   end

   // round to nearest: up when the remainder exceeds the floor root
   always_ff @(posedge clock) begin
      if (en) begin
         len_ff <= root_ff[W] + W'(rem_ff[W] > {2'b00, root_ff[W]});
      end
   end

   assign len_out = len_ff;

endmodule

`default_nettype wire

// ===== rtl/core/vns_div.sv =====
`default_nettype none

// Three-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
module vns_div #(
   parameter int COMPONENT_WIDTH = vns_pkg::COMPONENT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic [2:0][2*COMPONENT_WIDTH-1:0]    dvd_in,
   input  logic [COMPONENT_WIDTH-1:0]           dvs_in,
   output logic [2:0][2*COMPONENT_WIDTH-1:0]    quot_out,
   output logic [2:0][COMPONENT_WIDTH-1:0]      rem_out,
   output logic [COMPONENT_WIDTH-1:0]           dvs_out
);

   localparam int W = COMPONENT_WIDTH;
   localparam int S = 2 * W;

   logic [2:0][S-1:0] dvd_ff [1:S];
   logic [2:0][W-1:0] rem_ff [1:S];
   logic [W-1:0]      dvs_ff [1:S];

   for (genvar i = 0; i < S; i++) begin : g_step
      logic [2:0][S-1:0] dvd_prev;
      logic [2:0][W-1:0] rem_prev;
      logic [W-1:0]      dvs_prev;
      logic [2:0][S-1:0] dvd_in_st;
      logic [2:0][W-1:0] rem_in_st;

      if (i == 0) begin : g_first
         assign dvd_prev = dvd_in;
         assign rem_prev = '0;
         assign dvs_prev = dvs_in;
      end else begin : g_rest
         assign dvd_prev = dvd_ff[i];
         assign rem_prev = rem_ff[i];
         assign dvs_prev = dvs_ff[i];
      end

      always_comb begin
         logic [W:0] acc;
         logic       take;
         for (int j = 0; j < 3; j++) begin
            acc  = {rem_prev[j], dvd_prev[j][S-1]};
            take = (acc >= {1'b0, dvs_prev});
            rem_in_st[j] = take ? W'(acc - {1'b0, dvs_prev}) : acc[W-1:0];
            // dividend shifts out at the top while quotient bits fill in below
            dvd_in_st[j] = {dvd_prev[j][S-2:0], take};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dvd_ff[i+1] <= dvd_in_st;
            rem_ff[i+1] <= rem_in_st;
            dvs_ff[i+1] <= dvs_prev;
         end
      end
   end

   assign quot_out = dvd_ff[S];
   assign rem_out  = rem_ff[S];
   assign dvs_out  = dvs_ff[S];

endmodule

`default_nettype wire

// ===== rtl/core/vector3_normalize_scale.sv =====
`default_nettype none

//  Channel   Ports   Handshake      Beat
//  request   req_*   valid/ready    three components and a target length
//  response  rsp_*   valid/ready    rescaled components, length and flags
//
//  One beat per cycle is accepted while no response beat waits. A beat passes
//  through registers for squaring, summing, the square root (one bit per stage,
//  then rounding), the products and the divider (one quotient bit per stage
//  over a double-width product), then is rounded, clipped and offered on rsp_*.
//  Reset clears the valid bits only; the datapath needs no reset.
//  The whole pipeline holds while a response beat waits, so nothing is lost.
module vector3_normalize_scale #(
   parameter int COMPONENT_WIDTH = vns_pkg::COMPONENT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COMPONENT_WIDTH-1:0] req_comp_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_comp_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_comp_z,
   input  logic [COMPONENT_WIDTH-1:0]        req_target_magnitude,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_out_x,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_out_y,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_out_z,
   output logic [COMPONENT_WIDTH-1:0]        rsp_length_before,
   output logic                              rsp_zero_length,
   output logic                              rsp_saturated
);

   localparam int W = COMPONENT_WIDTH;
   localparam int N = 3 * W + 4;
   localparam logic [2*W:0] HALF = (2*W+1)'(1) << (W - 1);

   typedef struct packed {
      logic [2:0][W-1:0] raw;
      logic [2:0]        neg;
      logic [2:0][W-1:0] mag;
      logic [W-1:0]      target;
      logic              tzero;
   } side_type;

   logic              en;
   side_type          side_in;
   side_type          side_ff [0:N-1];
   logic [N-1:0]      vld_ff;
   logic [2:0][2*W-1:0] sq_in;
   logic [2:0][2*W-1:0] sq_ff;
   logic [2*W-1:0]    sum_ff;
   logic [W-1:0]      len_sq;
   logic [2:0][2*W-1:0] prod_ff;
   logic [W-1:0]      dvs_ff;
   logic [2:0][2*W-1:0] quot;
   logic [2:0][W-1:0] rem;
   logic [W-1:0]      dvs_end;
   logic [2:0][W-1:0] res_in;
   logic              sat_in;
   side_type          sd;

   logic              rsp_valid_ff;
   logic [2:0][W-1:0] res_ff;
   logic [W-1:0]      len_ff;
   logic              zero_ff;
   logic              sat_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_comb begin
      side_in.raw[0] = req_comp_x;
      side_in.raw[1] = req_comp_y;
      side_in.raw[2] = req_comp_z;
      for (int i = 0; i < 3; i++) begin
         side_in.neg[i] = side_in.raw[i][W-1];
         side_in.mag[i] = side_in.neg[i] ? (~side_in.raw[i] + W'(1)) : side_in.raw[i];
         sq_in[i] = {{W{1'b0}}, side_in.mag[i]} * {{W{1'b0}}, side_in.mag[i]};
      end
      side_in.target = req_target_magnitude;
      side_in.tzero  = (req_target_magnitude == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < N; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         sq_ff  <= sq_in;
         // three squares of at most 2^(2W-2) each cannot carry out of 2W bits
         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   vns_sqrt #(
      .COMPONENT_WIDTH (W)
   ) u_sqrt (
      .clock   (clock),
      .en      (en),
      .rad_in  (sum_ff),
      .len_out (len_sq)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= {{W{1'b0}}, side_ff[W+2].mag[i]}
                          * {{W{1'b0}}, side_ff[W+2].target};
         end
         dvs_ff <= len_sq;
      end
   end

   vns_div #(
      .COMPONENT_WIDTH (W)
   ) u_div (
      .clock    (clock),
      .en       (en),
      .dvd_in   (prod_ff),
      .dvs_in   (dvs_ff),
      .quot_out (quot),
      .rem_out  (rem),
      .dvs_out  (dvs_end)
   );

   assign sd = side_ff[N-1];

   // round magnitude half away from zero, clip to signed range; zero length/target passes raw
   always_comb begin
      logic [2*W:0] q_rnd;
      logic [W-1:0] q_lim;
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         q_rnd = {1'b0, quot[i]} + (2*W+1)'({rem[i], 1'b0} >= {1'b0, dvs_end});
         if (sd.neg[i] && (q_rnd > HALF)) begin
            sat_in = 1'b1;
            q_lim  = HALF[W-1:0];
         end else if (!sd.neg[i] && (q_rnd > HALF - (2*W+1)'(1))) begin
            sat_in = 1'b1;
            q_lim  = W'(HALF - (2*W+1)'(1));
         end else begin
            q_lim  = q_rnd[W-1:0];
         end
         res_in[i] = sd.neg[i] ? (W'(0) - q_lim) : q_lim;
      end
      if ((dvs_end == '0) || sd.tzero) begin
         res_in = sd.raw;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff  <= res_in;
         len_ff  <= dvs_end;
         zero_ff <= (dvs_end == '0);
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_x         = res_ff[0];
   assign rsp_out_y         = res_ff[1];
   assign rsp_out_z         = res_ff[2];
   assign rsp_length_before = len_ff;
   assign rsp_zero_length   = zero_ff;
   assign rsp_saturated     = sat_ff;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = vns_pkg::COMPONENT_WIDTH_DEFAULT;
   localparam int LATENCY = 3 * W + 5;
   localparam int N_RANDOM = 750;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic signed [W-1:0] z;
      logic [W-1:0]        len;
      logic                zero;
      logic                sat;
   } scaled_vec_type;

   // rounded square root, result rounded up when the remainder exceeds the root
   function automatic longint unsigned root_nearest(longint unsigned n);
      longint unsigned res, bitv, rem;
      res = 0;
      bitv = 64'd1 << 62;
      rem = n;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      if (rem > res) res += 1;
      return res;
   endfunction

   function automatic logic [W-1:0] rescale_comp(logic signed [W-1:0] c,
         longint unsigned tgt, longint unsigned len, ref logic sat);
      longint unsigned m, p, q, r;
      longint unsigned lim;
      m = (c < 0) ? longint'(-longint'(c)) : longint'(c);
      p = m * tgt;
      q = p / len;
      r = p % len;
      if (2 * r >= len) q += 1;
      if (c < 0) begin
         lim = 64'd1 << (W - 1);
         if (q > lim) begin
            sat = 1'b1;
            q = lim;
         end
         return W'(-q);
      end
      lim = (64'd1 << (W - 1)) - 1;
      if (q > lim) begin
         sat = 1'b1;
         q = lim;
      end
      return W'(q);
   endfunction

   function automatic scaled_vec_type normalise_vec(logic signed [W-1:0] x,
         logic signed [W-1:0] y, logic signed [W-1:0] z, logic [W-1:0] tgt);
      scaled_vec_type o;
      longint unsigned sum, len;
      logic sat;
      sum = longint'(x) * longint'(x) + longint'(y) * longint'(y)
            + longint'(z) * longint'(z);
      len = root_nearest(sum);
      sat = 1'b0;
      if (len == 0 || tgt == 0) begin
         o.x = x;
         o.y = y;
         o.z = z;
      end else begin
         o.x = rescale_comp(x, tgt, len, sat);
         o.y = rescale_comp(y, tgt, len, sat);
         o.z = rescale_comp(z, tgt, len, sat);
      end
      o.len = W'(len);
      o.zero = (sum == 0);
      o.sat = sat;
      return o;
   endfunction

   class vec_scoreboard;
      scaled_vec_type pending[$];
      int errors = 0;

      function void note_request(logic signed [W-1:0] x, logic signed [W-1:0] y,
            logic signed [W-1:0] z, logic [W-1:0] tgt);
         pending.push_back(normalise_vec(x, y, z, tgt));
      endfunction

      function void check_response(scaled_vec_type got);
         scaled_vec_type e;
         if (pending.size() == 0) begin
            $display("%0t: response beat with nothing outstanding: %p", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.x !== e.x) begin
            $display("%0t: out_x exp %0d got %0d", $time, e.x, got.x);
            errors++;
         end
         if (got.y !== e.y) begin
            $display("%0t: out_y exp %0d got %0d", $time, e.y, got.y);
            errors++;
         end
         if (got.z !== e.z) begin
            $display("%0t: out_z exp %0d got %0d", $time, e.z, got.z);
            errors++;
         end
         if (got.len !== e.len) begin
            $display("%0t: length_before exp %0d got %0d", $time, e.len, got.len);
            errors++;
         end
         if (got.zero !== e.zero) begin
            $display("%0t: zero_length exp %0b got %0b", $time, e.zero, got.zero);
            errors++;
         end
         if (got.sat !== e.sat) begin
            $display("%0t: saturated exp %0b got %0b", $time, e.sat, got.sat);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [W-1:0] req_comp_x = '0;
   logic signed [W-1:0] req_comp_y = '0;
   logic signed [W-1:0] req_comp_z = '0;
   logic [W-1:0] req_target_magnitude = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [W-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [W-1:0] rsp_length_before;
   logic rsp_zero_length, rsp_saturated;

   vec_scoreboard board = new();
   bit stimulus_done = 1'b0;
   bit long_hold = 1'b0;
   longint cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   vector3_normalize_scale DUT (.*);

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic send_vec(logic signed [W-1:0] x, logic signed [W-1:0] y,
         logic signed [W-1:0] z, logic [W-1:0] tgt, bit burst);
      int gap;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      req_target_magnitude <= tgt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(x, y, z, tgt);
   endtask

   function automatic logic [W-1:0] rand_comp();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return W'($urandom);
      if (r < 7) return W'($signed($urandom_range(0, 1024)) - 512);
      if (r < 8) return W'($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
      return '0;
   endfunction

   function automatic logic [W-1:0] rand_target();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 6) return W'($urandom_range(1, 1024));
      return W'($urandom);
   endfunction

   initial begin : stimulus
      logic [W-1:0] mx, mn;
      mx = 16'h7fff;
      mn = 16'h8000;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, zero vector, zero target, ties, saturation
      send_vec(0, 0, 0, 16'd256, 0);
      send_vec(0, 0, 0, 0, 0);
      send_vec(16'd256, 0, 0, 0, 0);
      send_vec(16'd256, 0, 0, 16'd512, 0);
      send_vec(mx, mx, mx, mx, 0);
      send_vec(mn, mn, mn, '1, 0);
      send_vec(mn, 0, 0, '1, 0);
      send_vec(mx, 0, 0, '1, 0);
      send_vec(1, 0, 0, '1, 0);
      send_vec(-1, 0, 0, '1, 0);
      send_vec(1, 1, 0, 1, 0);
      send_vec(-1, -1, 0, 1, 0);
      send_vec(3, -4, 0, 16'd5, 0);
      send_vec(3, -4, 12, 16'd13, 0);
      send_vec(mn, mx, 1, 16'd1, 0);
      send_vec(0, mn, 0, 16'h8000, 0);
      send_vec(0, 0, -16'sd256, 16'd256, 0);
      send_vec(16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 0);
      send_vec(16'haaaa, 16'h5555, 16'hff00, 16'h00ff, 0);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 3) long_hold = 1'b1;
         send_vec(rand_comp(), rand_comp(), rand_comp(), rand_target(),
                  long_hold);
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin : receiver
      int gap;
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response({rsp_out_x, rsp_out_y, rsp_out_z, rsp_length_before,
                               rsp_zero_length, rsp_saturated});
   end

   initial begin : finish_ctl
      wait (stimulus_done);
      while (board.pending.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clock);
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
      end else begin
         repeat (2 * LATENCY) @(posedge clock);
         if (board.errors == 0)
            $display("RESULT: OK");
         else
            $display("RESULT: ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT + 10) begin
         $display("%0t: timeout", $time);
         $display("RESULT: ERROR");
         $finish;
      end
   end
endmodule
